// ===== src/rrqs_pkg.sv =====
// Types, codes and constants shared by the round-robin quantum scheduler.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package rrqs_pkg;

  // Command kinds of an input word
  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_SLICE  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_ACCEPT = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  // Quantum register value after reset
  localparam logic [7:0] QUANTUM_RESET = 8'd10;

  typedef struct packed {
    logic        kind;
    logic [7:0]  task_tag;
    logic [15:0] burst;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] task_tag_res;
    logic [7:0] slice_length;
    logic       task_done;
  } out_word_t;

  // One task table entry as held in the task memory
  typedef struct packed {
    logic [7:0]  tag;
    logic [15:0] remaining;
  } entry_t;

endpackage
`default_nettype wire

// ===== src/round_robin_quantum_scheduler_top.sv =====
// Round-robin scheduler with a programmable quantum: sequencer, live bits and result register.
// Depends on rrqs_pkg and instantiates rrqs_store for the task table.
//
// Usage
//   Input channel in_valid/in_ready/in_data carries one command word: add a task
//   (tag and burst) or take one scheduling step. Every command returns exactly one
//   word on out_valid/out_ready/out_data: slice granted, idle, accepted or full.
//   cfg_wr_en/cfg_wr_data write the quantum at any edge; 0 acts as 1.
// Sequencing
//   One command is in flight at a time. An add passes from rest to the add state,
//   which writes the result word. A step visits slots in rotation, at most
//   MAX_TASKS, and reads each live entry it meets from the task memory; it
//   reports idle once every slot in use has been visited without a slice.
// Reset
//   rst_n (synchronous, low) clears all live bits, the task and live counts, the
//   scan position and the output valid flag, and sets the quantum to 10. The task
//   memory is not cleared; only entries written by an add are ever read.
// Stall
//   A finished word waits in the output register. in_ready returns once the
//   sequencer is back at rest, so the next command is taken while the previous
//   word is still held; a new result waits in its state until the register frees.
`default_nettype none
module round_robin_quantum_scheduler_top
  import rrqs_pkg::*;
#(
  parameter int MAX_TASKS = 16
) (
  input  wire logic [0:0] clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_word_t   in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_word_t       out_data,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data
);

  localparam int AW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_TASKS);

  // Sequencer states
  localparam logic [1:0] S_REST = 2'd0;
  localparam logic [1:0] S_ADD  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_READ = 2'd3;

  logic [1:0]           state_r, state_nxt;
  in_word_t             item_r, item_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        live_cnt_r, live_cnt_nxt;
  logic [CW-1:0]        visit_r, visit_nxt;
  logic [AW-1:0]        scan_r, scan_nxt;
  logic [AW-1:0]        pos_r, pos_nxt;
  logic [MAX_TASKS-1:0] live_r, live_nxt;
  logic [7:0]           quantum_r;
  logic                 out_valid_r, out_valid_nxt;
  out_word_t            out_data_r, out_data_nxt;

  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  entry_t        rd_data, wr_data;

  logic          out_free;
  logic [7:0]    quantum_eff;
  logic [AW-1:0] pos_step;
  logic [CW-1:0] count_less;
  logic [7:0]    slice_len;
  logic [15:0]   rem_left;
  logic          slice_done;
  logic [CW-1:0] live_left;

  rrqs_store #(
    .DEPTH (MAX_TASKS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign in_ready  = (state_r == S_REST);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  // Slice arithmetic on the entry just read
  assign quantum_eff = (quantum_r == 8'd0) ? 8'd1 : quantum_r;
  assign slice_len   = (rd_data.remaining < {8'd0, quantum_eff}) ?
                       rd_data.remaining[7:0] : quantum_eff;
  assign rem_left    = rd_data.remaining - {8'd0, slice_len};
  assign slice_done  = (rem_left == 16'd0);
  assign live_left   = slice_done ? (live_cnt_r - CW'(1)) : live_cnt_r;

  // Step one slot down the rotation, wrapping from slot 0 to the highest slot in use
  assign count_less = count_r - CW'(1);
  assign pos_step   = (pos_r == '0) ? count_less[AW-1:0] : (pos_r - AW'(1));

  // Sequence the command in hand
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    count_nxt     = count_r;
    live_cnt_nxt  = live_cnt_r;
    visit_nxt     = visit_r;
    scan_nxt      = scan_r;
    pos_nxt       = pos_r;
    live_nxt      = live_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    rd_en         = 1'b0;
    rd_addr       = pos_step;
    wr_en         = 1'b0;
    wr_addr       = pos_r;
    wr_data       = '{tag: rd_data.tag, remaining: rem_left};

    unique case (state_r)
      S_REST: begin
        if (in_valid) begin
          item_nxt  = in_data;
          visit_nxt = '0;
          pos_nxt   = ({{(CW-AW){1'b0}}, scan_r} < count_r) ? scan_r : '0;
          state_nxt = (in_data.kind == KIND_ADD) ? S_ADD : S_SCAN;
        end
      end
      S_ADD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_REST;
          if (count_r == FULL_COUNT) begin
            out_data_nxt = '{status: ST_FULL, task_tag_res: item_r.task_tag,
                             slice_length: 8'd0, task_done: 1'b0};
          end else begin
            wr_en        = 1'b1;
            wr_addr      = count_r[AW-1:0];
            wr_data      = '{tag: item_r.task_tag, remaining: item_r.burst};
            live_nxt[count_r[AW-1:0]] = 1'b1;
            count_nxt    = count_r + CW'(1);
            live_cnt_nxt = live_cnt_r + CW'(1);
            out_data_nxt = '{status: ST_ACCEPT, task_tag_res: item_r.task_tag,
                             slice_length: 8'd0, task_done: 1'b0};
          end
        end
      end
      S_SCAN: begin
        if (visit_r == count_r) begin
          // Nothing live: report idle and empty the table
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{status: ST_IDLE, task_tag_res: 8'd0,
                              slice_length: 8'd0, task_done: 1'b0};
            count_nxt     = '0;
            live_cnt_nxt  = '0;
            scan_nxt      = '0;
            state_nxt     = S_REST;
          end
        end else begin
          pos_nxt   = pos_step;
          visit_nxt = visit_r + CW'(1);
          if (live_r[pos_step]) begin
            rd_en     = 1'b1;
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        if (rd_data.remaining == 16'd0) begin
          // Drop a zero-burst task and carry on scanning
          live_nxt[pos_r] = 1'b0;
          live_cnt_nxt    = live_cnt_r - CW'(1);
          state_nxt       = S_SCAN;
        end else if (out_free) begin
          wr_en         = 1'b1;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{status: ST_SLICE, task_tag_res: rd_data.tag,
                            slice_length: slice_len, task_done: slice_done};
          if (slice_done) begin
            live_nxt[pos_r] = 1'b0;
          end
          live_cnt_nxt = live_left;
          if (live_left == '0) begin
            count_nxt = '0;
            scan_nxt  = '0;
          end else begin
            scan_nxt = pos_r;
          end
          state_nxt = S_REST;
        end
      end
      default: begin
        state_nxt = S_REST;
      end
    endcase
  end

  // Advance control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_REST;
      count_r     <= '0;
      live_cnt_r  <= '0;
      scan_r      <= '0;
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      live_cnt_r  <= live_cnt_nxt;
      scan_r      <= scan_nxt;
      live_r      <= live_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold payload and scan working registers
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    visit_r    <= visit_nxt;
    pos_r      <= pos_nxt;
    out_data_r <= out_data_nxt;
  end

  // Quantum register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r <= QUANTUM_RESET;
    end else if (cfg_wr_en) begin
      quantum_r <= cfg_wr_data;
    end
  end

`ifndef SYNTHESIS
  a_live_within_count: assert property (@(posedge clk) disable iff (!rst_n)
    live_cnt_r <= count_r)
    else $error("live task count exceeds slots in use");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_COUNT)
    else $error("slot count beyond table depth");

  a_read_then_check: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> (state_r == S_READ))
    else $error("memory read not followed by entry check");

  a_slice_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == ST_SLICE) |->
      (out_data_r.slice_length != 8'd0))
    else $error("granted slice of zero length");

  a_write_only_when_emitting: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> out_valid_r)
    else $error("table written without a result word");
`endif

endmodule
`default_nettype wire

// ===== src/rrqs_store.sv =====
// Task memory: one write port and one registered read port.
// Depends on rrqs_pkg for the entry type.
`default_nettype none
module rrqs_store
  import rrqs_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output entry_t             rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire entry_t        wr_data
);

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  // Write the addressed entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read and hold the data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== sim/round_robin_quantum_scheduler_top_tb.sv =====
// Self-checking testbench for the round-robin quantum scheduler top level.
// Depends on rrqs_pkg and round_robin_quantum_scheduler_top; holds its own task-table predictor.
`timescale 1ns / 100ps
module round_robin_quantum_scheduler_top_tb;
  import rrqs_pkg::*;

  localparam int TASK_SLOTS  = 16;
  localparam int SCAN_CYCLES = 2 + 3 * TASK_SLOTS;
  localparam int QUIET_LIMIT = 5000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_word_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_word_t  out_data;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = '0;

  // Predicted task table
  logic [7:0]  tag_tbl  [TASK_SLOTS];
  logic [15:0] left_tbl [TASK_SLOTS];
  logic        live_tbl [TASK_SLOTS];
  int          slots_used = 0;
  int          last_served = 0;
  logic [7:0]  quantum_q = QUANTUM_RESET;

  out_word_t pending_words[$];

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int hold_off_len = 0;
  int hold_off_seq = 0;
  int fail_count = 0;
  int words_in = 0;
  int words_out = 0;
  int n_slice = 0;
  int n_idle = 0;
  int n_accept = 0;
  int n_full = 0;

  round_robin_quantum_scheduler_top #(
    .MAX_TASKS (TASK_SLOTS)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Work out the result word of one command and advance the predicted table
  function automatic out_word_t schedule_next(in_word_t w);
    out_word_t  r;
    int         pos;
    int         n;
    int         k;
    bit         any_live;
    logic [7:0] q;
    logic [7:0] len;
    r = '0;
    q = (quantum_q == 8'd0) ? 8'd1 : quantum_q;
    if (w.kind == KIND_ADD) begin
      r.task_tag_res = w.task_tag;
      if (slots_used >= TASK_SLOTS) begin
        r.status = ST_FULL;
        return r;
      end
      tag_tbl[slots_used]  = w.task_tag;
      left_tbl[slots_used] = w.burst;
      live_tbl[slots_used] = 1'b1;
      slots_used++;
      r.status = ST_ACCEPT;
      return r;
    end
    pos = (last_served < slots_used) ? last_served : 0;
    for (n = 0; n < slots_used; n++) begin
      pos = (pos == 0) ? slots_used - 1 : pos - 1;
      if (!live_tbl[pos]) continue;
      // retire a zero-burst task without a slice
      if (left_tbl[pos] == 16'd0) begin
        live_tbl[pos] = 1'b0;
        continue;
      end
      len = (left_tbl[pos] < {8'd0, q}) ? left_tbl[pos][7:0] : q;
      left_tbl[pos] = left_tbl[pos] - {8'd0, len};
      r.status       = ST_SLICE;
      r.task_tag_res = tag_tbl[pos];
      r.slice_length = len;
      r.task_done    = (left_tbl[pos] == 16'd0);
      if (r.task_done) live_tbl[pos] = 1'b0;
      last_served = pos;
      // empty the table once nothing is live
      any_live = 1'b0;
      for (k = 0; k < slots_used; k++) if (live_tbl[k]) any_live = 1'b1;
      if (!any_live) begin
        slots_used  = 0;
        last_served = 0;
      end
      return r;
    end
    slots_used  = 0;
    last_served = 0;
    r.status = ST_IDLE;
    return r;
  endfunction

  // Offer one command word and hold it until accepted
  task automatic send_cmd(logic kind, logic [7:0] tag, logic [15:0] burst);
    in_word_t w;
    w.kind     = kind;
    w.task_tag = tag;
    w.burst    = burst;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    words_in++;
    pending_words.push_back(schedule_next(w));
  endtask

  // Drop valid, wait for every outstanding word, then let a full scan elapse
  task automatic idle_pause();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SCAN_CYCLES) @(posedge clk);
  endtask

  task automatic set_quantum(logic [7:0] q);
    idle_pause();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= q;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    quantum_q = q;
  endtask

  // Step with the widest quantum until the table has emptied
  task automatic drain_table();
    set_quantum(8'd255);
    while (slots_used != 0) send_cmd(KIND_STEP, 8'd0, 16'd0);
  endtask

  task automatic test_corner_commands();
    send_cmd(KIND_STEP, 8'd0, 16'd0);
    send_cmd(KIND_ADD, 8'h00, 16'd0);
    send_cmd(KIND_ADD, 8'hFF, 16'd25);
    send_cmd(KIND_ADD, 8'h5A, 16'd10);
    repeat (5) send_cmd(KIND_STEP, 8'd0, 16'd0);
    idle_pause();
  endtask

  task automatic test_table_full();
    int i;
    set_quantum(8'd255);
    for (i = 0; i < TASK_SLOTS; i++) begin
      if (i == 0) send_cmd(KIND_ADD, 8'hFF, 16'hFFFF);
      else send_cmd(KIND_ADD, 8'(i * 17), (i % 4 == 0) ? 16'd0 : 16'(i * 20));
    end
    send_cmd(KIND_ADD, 8'h77, 16'd5);
    drain_table();
    idle_pause();
  endtask

  task automatic test_zero_quantum();
    set_quantum(8'd0);
    send_cmd(KIND_ADD, 8'h11, 16'd2);
    send_cmd(KIND_ADD, 8'h22, 16'd1);
    repeat (4) send_cmd(KIND_STEP, 8'd0, 16'd0);
    idle_pause();
  endtask

  // Hold the result channel off while commands keep coming, so the input stalls
  task automatic test_output_backpressure();
    int i;
    set_quantum(QUANTUM_RESET);
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_off_len   = 300;
    hold_off_seq++;
    for (i = 0; i < 8; i++) begin
      send_cmd(KIND_ADD, 8'($urandom_range(255)), 16'($urandom_range(1, 30)));
    end
    repeat (16) send_cmd(KIND_STEP, 8'd0, 16'd0);
    idle_pause();
  endtask

  task automatic test_random_traffic(int n_items, logic [7:0] q);
    int          i;
    int          add_bias;
    int unsigned r;
    logic        kind;
    logic [7:0]  tag;
    logic [15:0] burst;
    add_bias = 50;
    set_quantum(q);
    for (i = 0; i < n_items; i++) begin
      // swing between filling and draining the table
      if (i % 40 == 0) add_bias = $urandom_range(1) ? 70 : 30;
      kind = ($urandom_range(99) < add_bias) ? KIND_ADD : KIND_STEP;
      tag  = 8'($urandom_range(255));
      r    = $urandom_range(63);
      if (r < 8) burst = 16'd0;
      else if (r == 63 && quantum_q >= 8'd128) burst = 16'($urandom_range(701, 4095));
      else if (r < 52) burst = 16'($urandom_range(1, 40));
      else burst = 16'($urandom_range(41, 700));
      send_cmd(kind, tag, burst);
    end
    drain_table();
  endtask

  // Result channel ready, with an occasional long hold-off
  int hold_count = 0;
  int hold_seen = 0;
  always @(posedge clk) begin
    if (hold_seen != hold_off_seq) begin
      hold_seen  = hold_off_seq;
      hold_count = hold_off_len;
    end
    if (hold_count > 0) begin
      hold_count--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Compare each result word with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin : check_word
      out_word_t want;
      words_out++;
      if (pending_words.size() == 0) begin
        $error("result word with none pending: status %0d tag %0d", out_data.status,
               out_data.task_tag_res);
        fail_count++;
      end else begin
        want = pending_words.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          fail_count++;
        end
        if (out_data.task_tag_res !== want.task_tag_res) begin
          $error("task_tag_res: expected %0d, got %0d", want.task_tag_res,
                 out_data.task_tag_res);
          fail_count++;
        end
        if (out_data.slice_length !== want.slice_length) begin
          $error("slice_length: expected %0d, got %0d", want.slice_length,
                 out_data.slice_length);
          fail_count++;
        end
        if (out_data.task_done !== want.task_done) begin
          $error("task_done: expected %0d, got %0d", want.task_done, out_data.task_done);
          fail_count++;
        end
        case (want.status)
          ST_SLICE:  n_slice++;
          ST_IDLE:   n_idle++;
          ST_ACCEPT: n_accept++;
          default:   n_full++;
        endcase
      end
    end
  end

  // Abort when no word moves on either channel for too long
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    int         p;
    logic [7:0] phase_q [8];
    int         src_mix [4];
    int         sink_mix [4];
    phase_q  = '{8'd1, 8'd255, 8'd10, 8'($urandom_range(2, 254)), 8'd0,
                 8'($urandom_range(2, 254)), 8'd128, 8'($urandom_range(2, 254))};
    src_mix  = '{0, 68, 0, 16};
    sink_mix = '{0, 0, 68, 16};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_corner_commands();
    test_table_full();
    test_zero_quantum();
    test_output_backpressure();
    for (p = 0; p < 8; p++) begin
      src_idle_pct   = src_mix[p % 4];
      sink_stall_pct = sink_mix[p % 4];
      test_random_traffic(140, phase_q[p]);
    end

    idle_pause();
    $display("Sent %0d commands, checked %0d results", words_in, words_out);
    $display("(%0d slices, %0d idle, %0d accepted, %0d full)",
             n_slice, n_idle, n_accept, n_full);
    $display("Quantum swept over 0, 1, 10, 128, 255 and random values under four idling mixes");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/rrqs_pkg.sv
src/rrqs_store.sv
src/round_robin_quantum_scheduler_top.sv
sim/round_robin_quantum_scheduler_top_tb.sv
